// ===== hdl/pcs_pkg.sv =====
// Shared constants and controller/datapath interface types for PUCT child selection.
`timescale 1ns / 1ps
`default_nettype none
package pcs_pkg;
  localparam int MAX_CHILDREN = 8;
  localparam int CNT_W = $clog2(MAX_CHILDREN);
  localparam int DIV_STEPS = 34;
  localparam int SQRT_STEPS = 24;
  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam logic [15:0] EXPLORE_RESET = 16'd8192;

  typedef struct packed {
    logic load;
    logic div_step;
    logic sqrt_step;
    logic mul1;
    logic mul2;
    logic start2;
    logic score;
    logic emit;
  } pcs_cmd_t;

  typedef struct packed {
    logic emit_due;
    logic out_free;
  } pcs_status_t;
endpackage
`default_nettype wire

// ===== hdl/pcs_ctrl.sv =====
// Sequencer for the per-child scoring steps.
`timescale 1ns / 1ps
`default_nettype none
module pcs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pcs_pkg::pcs_status_t status,
  output pcs_pkg::pcs_cmd_t       cmd
);
  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_RUN1   = 8'b00000010,
    S_MUL1   = 8'b00000100,
    S_MUL2   = 8'b00001000,
    S_START2 = 8'b00010000,
    S_RUN2   = 8'b00100000,
    S_SCORE  = 8'b01000000,
    S_FINISH = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic [pcs_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic last_step;

  assign last_step = (cnt_r == pcs_pkg::STEP_W'(pcs_pkg::DIV_STEPS - 1));
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_RUN1;
        end
      end
      S_RUN1: begin
        cmd.div_step = 1'b1;
        cmd.sqrt_step = (cnt_r < pcs_pkg::STEP_W'(pcs_pkg::SQRT_STEPS));
        cnt_nxt = cnt_r + 1'b1;
        if (last_step) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_nxt = S_START2;
      end
      S_START2: begin
        cmd.start2 = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_RUN2;
      end
      S_RUN2: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (last_step) begin
          state_nxt = S_SCORE;
        end
      end
      S_SCORE: begin
        // The second quotient is complete only after the last divide step.
        cmd.score = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // When a word is due, hold here until the output register can take it.
        if (!status.emit_due) begin
          state_nxt = S_IDLE;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_RUN1) && (cnt_r == '0))
    else $error("load did not start the first phase");
  a_emit_due: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.emit_due && status.out_free)
    else $error("emit without a free output");
`endif
endmodule
`default_nettype wire

// ===== hdl/pcs_dp.sv =====
// Datapath: divider, square root, multipliers, running best and output register.
`timescale 1ns / 1ps
`default_nettype none
module pcs_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pcs_pkg::pcs_cmd_t  cmd,
  output pcs_pkg::pcs_status_t    status,
  input  wire logic               cfg_wr_en,
  input  wire logic [15:0]        cfg_wr_data,
  input  wire logic [5:0]         in_child_action,
  input  wire logic [15:0]        in_parent_visits,
  input  wire logic [15:0]        in_child_visits,
  input  wire logic signed [31:0] in_child_value_sum,
  input  wire logic [7:0]         in_child_pending_loss,
  input  wire logic [15:0]        in_child_prior,
  input  wire logic               in_last_child,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [5:0]              out_chosen_action,
  output logic signed [31:0]      out_chosen_score,
  output logic [7:0]              out_chosen_loss_next
);
  logic [15:0] cw_r;
  logic [5:0] act_r;
  logic [15:0] nv_r, prior_r;
  logic [7:0] loss_r;
  logic last_r, neg_r, nz_r;

  logic [33:0] dq_r;
  logic [16:0] drem_r, dsor_r;
  logic [47:0] srad_r;
  logic [26:0] srem_r;
  logic [23:0] sroot_r;
  logic [39:0] p1_r;
  logic [55:0] p2_r;
  logic signed [35:0] q_r;

  logic signed [31:0] best_score_r;
  logic [5:0] best_action_r;
  logic [7:0] best_loss_r;
  logic best_valid_r, emit_r;
  logic [pcs_pkg::CNT_W-1:0] count_r;

  logic out_valid_r;
  logic [5:0] out_action_r;
  logic signed [31:0] out_score_r;
  logic [7:0] out_loss_r;

  logic signed [33:0] adj;
  logic [17:0] dtrial;
  logic dbit;
  logic [26:0] srem2, strial;
  logic sbit;
  logic signed [34:0] m_val;
  logic signed [35:0] x_val;
  logic signed [36:0] sum;
  logic signed [31:0] sc;
  logic take;

  assign adj = {{2{in_child_value_sum[31]}}, in_child_value_sum}
             + $signed({10'b0, in_child_pending_loss, 16'b0});
  assign dtrial = {drem_r, dq_r[33]};
  assign dbit = (dtrial >= {1'b0, dsor_r});
  assign srem2 = {srem_r[24:0], srad_r[47:46]};
  assign strial = {1'b0, sroot_r, 2'b01};
  assign sbit = (srem2 >= strial);

  // Quotient carries the magnitude; the sign comes back here.
  assign m_val = neg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});
  assign x_val = 36'sd65536 - {m_val[34], m_val};

  assign sum = {q_r[35], q_r} + $signed({9'b0, dq_r[27:0]});
  always_comb begin
    if (sum > 37'sd2147483647) begin
      sc = 32'sh7fffffff;
    end else if (sum < -37'sd2147483648) begin
      sc = 32'sh80000000;
    end else begin
      sc = sum[31:0];
    end
  end
  assign take = !best_valid_r || (sc > best_score_r);

  assign status.emit_due = emit_r;
  assign status.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_child_action;
      nv_r <= in_child_visits;
      loss_r <= in_child_pending_loss;
      prior_r <= in_child_prior;
      last_r <= in_last_child;
      neg_r <= adj[33];
      nz_r <= (in_child_visits == 16'd0);
      dq_r <= adj[33] ? 34'(-adj) : 34'(adj);
      drem_r <= '0;
      dsor_r <= {1'b0, in_child_visits};
      srad_r <= {in_parent_visits, 32'b0};
      srem_r <= '0;
      sroot_r <= '0;
    end else begin
      if (cmd.div_step) begin
        drem_r <= dbit ? 17'(dtrial - {1'b0, dsor_r}) : dtrial[16:0];
        dq_r <= {dq_r[32:0], dbit};
      end
      if (cmd.sqrt_step) begin
        srem_r <= sbit ? (srem2 - strial) : srem2;
        sroot_r <= {sroot_r[22:0], sbit};
        srad_r <= {srad_r[45:0], 2'b00};
      end
      if (cmd.start2) begin
        dq_r <= {6'b0, p2_r[55:28]};
        drem_r <= '0;
        dsor_r <= {1'b0, nv_r} + 17'd1;
      end
    end
    if (cmd.mul1) begin
      p1_r <= cw_r * sroot_r;
      q_r <= nz_r ? 36'sd0 : ((x_val + $signed({35'b0, x_val[35]})) >>> 1);
    end
    if (cmd.mul2) begin
      p2_r <= p1_r * prior_r;
    end
    if (cmd.emit) begin
      out_action_r <= best_action_r;
      out_score_r <= best_score_r;
      out_loss_r <= (best_loss_r == 8'd255) ? 8'd255 : best_loss_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= pcs_pkg::EXPLORE_RESET;
      best_score_r <= 32'sh80000000;
      best_action_r <= '0;
      best_loss_r <= '0;
      best_valid_r <= 1'b0;
      count_r <= '0;
      emit_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cw_r <= cfg_wr_data;
      end
      if (cmd.score) begin
        if (take) begin
          best_score_r <= sc;
          best_action_r <= act_r;
          best_loss_r <= loss_r;
        end
        best_valid_r <= 1'b1;
        emit_r <= last_r || (count_r == pcs_pkg::CNT_W'(pcs_pkg::MAX_CHILDREN - 1));
        count_r <= count_r + 1'b1;
      end
      if (cmd.emit) begin
        best_score_r <= 32'sh80000000;
        best_action_r <= '0;
        best_loss_r <= '0;
        best_valid_r <= 1'b0;
        count_r <= '0;
        emit_r <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_chosen_action = out_action_r;
  assign out_chosen_score = out_score_r;
  assign out_chosen_loss_next = out_loss_r;

`ifndef NO_ASSERTIONS
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> !best_valid_r && (count_r == '0) && out_valid_r)
    else $error("emit did not clear the running best");
  a_score_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.score |=> best_valid_r)
    else $error("scored child left no running best");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_score_r))
    else $error("stalled output word changed");
`endif
endmodule
`default_nettype wire

// ===== hdl/puct_child_select_core.sv =====
// Top level of PUCT child selection: controller plus datapath.
//   channel   direction  handshake            payload
//   in_       input      in_valid/in_stall    one child's statistics
//   out_      output     out_valid/out_stall  winner of one node
//   cfg_      input      cfg_wr_en            explore weight (Q4.12)
// Each child passes from acceptance to the next acceptance through two passes of
// a 34-step bit-serial divider (the square root runs during the first), two
// multiplies and a scoring step. in_stall is high while a child is in work and
// while a finished word waits for a full output register. Reset is synchronous.
`timescale 1ns / 1ps
`default_nettype none
module puct_child_select_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [15:0]        cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [5:0]         in_child_action,
  input  wire logic [15:0]        in_parent_visits,
  input  wire logic [15:0]        in_child_visits,
  input  wire logic signed [31:0] in_child_value_sum,
  input  wire logic [7:0]         in_child_pending_loss,
  input  wire logic [15:0]        in_child_prior,
  input  wire logic               in_last_child,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [5:0]              out_chosen_action,
  output logic signed [31:0]      out_chosen_score,
  output logic [7:0]              out_chosen_loss_next
);
  pcs_pkg::pcs_cmd_t cmd;
  pcs_pkg::pcs_status_t status;

  pcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pcs_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .status                (status),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_child_action       (in_child_action),
    .in_parent_visits      (in_parent_visits),
    .in_child_visits       (in_child_visits),
    .in_child_value_sum    (in_child_value_sum),
    .in_child_pending_loss (in_child_pending_loss),
    .in_child_prior        (in_child_prior),
    .in_last_child         (in_last_child),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_chosen_action     (out_chosen_action),
    .out_chosen_score      (out_chosen_score),
    .out_chosen_loss_next  (out_chosen_loss_next)
  );
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the PUCT child selection core.
`timescale 1ns / 1ps
module tb_top;
  localparam int LIMIT_CYCLES = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [5:0] in_child_action = '0;
  logic [15:0] in_parent_visits = '0;
  logic [15:0] in_child_visits = '0;
  logic signed [31:0] in_child_value_sum = '0;
  logic [7:0] in_child_pending_loss = '0;
  logic [15:0] in_child_prior = '0;
  logic in_last_child = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] out_chosen_action;
  logic signed [31:0] out_chosen_score;
  logic [7:0] out_chosen_loss_next;

  typedef struct packed {
    logic [5:0] action;
    logic signed [31:0] score;
    logic [7:0] loss_next;
  } winner_t;

  winner_t winners_due[$];
  int fail_count = 0;
  int cycle_count = 0;
  int out_stall_bias = 0;
  bit in_gaps_on = 1'b1;

  // Predictor state, mirroring the block.
  logic [15:0] weight_q;
  logic signed [31:0] lead_score;
  logic [5:0] lead_action;
  logic [7:0] lead_loss;
  bit lead_valid;
  int children_seen;

  puct_child_select_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_child_action(in_child_action), .in_parent_visits(in_parent_visits),
    .in_child_visits(in_child_visits), .in_child_value_sum(in_child_value_sum),
    .in_child_pending_loss(in_child_pending_loss), .in_child_prior(in_child_prior),
    .in_last_child(in_last_child),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_chosen_action(out_chosen_action), .out_chosen_score(out_chosen_score),
    .out_chosen_loss_next(out_chosen_loss_next)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t timeout", $time);
      $display("** puct_child_select_core: FAILED **");
      $finish;
    end
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 120);
  endfunction

  function automatic logic [63:0] sqrt_q16(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Scores one child and updates the running winner; queues a word on node end.
  task automatic score_child(logic [5:0] act, logic [15:0] pv, logic [15:0] nv,
                             logic signed [31:0] vsum, logic [7:0] loss,
                             logic [15:0] prior, logic last);
    longint q, m, adj, total;
    logic [63:0] s;
    logic [127:0] prod;
    logic [63:0] e;
    logic signed [31:0] sc;
    winner_t w;
    q = 0;
    if (nv != 0) begin
      adj = longint'(vsum) + longint'(loss) * 65536;
      m = adj / longint'(nv);
      q = (65536 - m) / 2;
    end
    s = sqrt_q16({16'd0, pv, 32'd0});
    prod = 128'(weight_q) * 128'(s) * 128'(prior);
    prod = prod / (128'(nv) + 1);
    e = 64'(prod >> 28);
    total = q + longint'(e);
    if (total > 64'sd2147483647) total = 64'sd2147483647;
    if (total < -64'sd2147483648) total = -64'sd2147483648;
    sc = 32'(total);
    if (!lead_valid || sc > lead_score) begin
      lead_score = sc;
      lead_action = act;
      lead_loss = loss;
      lead_valid = 1'b1;
    end
    children_seen++;
    if (last || children_seen >= pcs_pkg::MAX_CHILDREN) begin
      w.action = lead_action;
      w.score = lead_score;
      w.loss_next = (lead_loss == 8'd255) ? 8'd255 : lead_loss + 8'd1;
      winners_due.push_back(w);
      lead_valid = 1'b0;
      lead_score = 32'sh80000000;
      lead_action = '0;
      lead_loss = '0;
      children_seen = 0;
    end
  endtask

  task automatic send_child(logic [5:0] act, logic [15:0] pv, logic [15:0] nv,
                            logic signed [31:0] vsum, logic [7:0] loss,
                            logic [15:0] prior, logic last);
    int gap;
    gap = in_gaps_on ? rand_gap() : 0;
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    in_child_action <= act;
    in_parent_visits <= pv;
    in_child_visits <= nv;
    in_child_value_sum <= vsum;
    in_child_pending_loss <= loss;
    in_child_prior <= prior;
    in_last_child <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    score_child(act, pv, nv, vsum, loss, prior, last);
    in_valid <= 1'b0;
    // The block stalls while it scores the accepted child, so this edge costs nothing.
    @(posedge clk);
  endtask

  // Random child with value sums mostly near the plausible range.
  task automatic send_random_child(logic last);
    logic [15:0] nv;
    logic signed [31:0] vsum;
    nv = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    case ($urandom_range(0, 3))
      0: vsum = 32'($urandom);
      default: vsum = 32'($signed($urandom_range(0, 131072 * 40)) - 65536 * 40);
    endcase
    send_child(6'($urandom), ($urandom_range(0, 4) == 0) ? 16'($urandom) :
               16'($urandom_range(0, 500)), nv, vsum, 8'($urandom_range(0, 3) == 0 ?
               $urandom : $urandom_range(0, 4)), 16'($urandom), last);
  endtask

  task automatic wait_drained();
    while (winners_due.size() != 0) @(posedge clk);
    // A node in progress may still be scoring a child after the last word.
    repeat (100) @(posedge clk);
  endtask

  task automatic write_weight(logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    weight_q = value;
  endtask

  always @(posedge clk) begin
    winner_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (winners_due.size() == 0) begin
        $display("%0t unexpected word: action %0d score %0d loss %0d", $time,
                 out_chosen_action, out_chosen_score, out_chosen_loss_next);
        fail_count++;
      end else begin
        w = winners_due.pop_front();
        if (out_chosen_action !== w.action) begin
          $display("%0t action exp %0d got %0d", $time, w.action, out_chosen_action);
          fail_count++;
        end
        if (out_chosen_score !== w.score) begin
          $display("%0t score exp %0d got %0d", $time, w.score, out_chosen_score);
          fail_count++;
        end
        if (out_chosen_loss_next !== w.loss_next) begin
          $display("%0t loss exp %0d got %0d", $time, w.loss_next,
                   out_chosen_loss_next);
          fail_count++;
        end
      end
    end
  end

  // Output stall: random bursts, with phases of no stall at all.
  always @(posedge clk) begin
    if (out_stall_bias == 0) out_stall <= 1'b0;
    else if ($urandom_range(0, 99) < 3) out_stall <= 1'b1;
    else if (out_stall && $urandom_range(0, 99) < 30) out_stall <= 1'b0;
    else if ($urandom_range(0, 99) < out_stall_bias) out_stall <= 1'b1;
  end

  task automatic test_extremes();
    send_child(6'd0, 16'd0, 16'd0, 32'sd0, 8'd0, 16'd0, 1'b1);
    send_child(6'd63, 16'hFFFF, 16'hFFFF, 32'sh7FFFFFFF, 8'd255, 16'hFFFF, 1'b0);
    send_child(6'd21, 16'hFFFF, 16'd0, 32'sh80000000, 8'd254, 16'hFFFF, 1'b1);
    // Hugely negative score from a single visit must still win as first child.
    send_child(6'd42, 16'd0, 16'd1, 32'sh7FFFFFFF, 8'd255, 16'd0, 1'b1);
    send_child(6'd5, 16'd1, 16'd1, 32'sh80000000, 8'd0, 16'd1, 1'b1);
    // Equal scores: the first one keeps the lead.
    send_child(6'd10, 16'd100, 16'd3, 32'sd65536, 8'd1, 16'd3000, 1'b0);
    send_child(6'd11, 16'd100, 16'd3, 32'sd65536, 8'd1, 16'd3000, 1'b1);
    // Running past the child limit without a last mark.
    for (int i = 0; i < pcs_pkg::MAX_CHILDREN + 2; i++)
      send_child(6'(i * 7), 16'(i * 13), 16'(i), 32'(i * 40000 - 150000), 8'(i),
                 16'(i * 6000), i == pcs_pkg::MAX_CHILDREN + 1);
    wait_drained();
  endtask

  task automatic test_weights();
    logic [15:0] settings[4] = '{16'd0, 16'hFFFF, 16'd1, 16'd20000};
    foreach (settings[k]) begin
      write_weight(settings[k]);
      for (int i = 0; i < 30; i++) send_random_child($urandom_range(0, 3) == 0);
      send_random_child(1'b1);
      wait_drained();
    end
    write_weight(pcs_pkg::EXPLORE_RESET);
  endtask

  task automatic test_random_nodes();
    int sent, kids;
    sent = 0;
    while (sent < 1200) begin
      if ($urandom_range(0, 9) == 0) begin
        out_stall_bias = (out_stall_bias == 0) ? $urandom_range(5, 60) : 0;
        in_gaps_on = $urandom_range(0, 3) != 0;
      end
      kids = $urandom_range(1, pcs_pkg::MAX_CHILDREN + 1);
      for (int i = 0; i < kids; i++) begin
        send_random_child(i == kids - 1 && $urandom_range(0, 9) != 0);
        sent++;
      end
    end
    send_random_child(1'b1);
    wait_drained();
  endtask

  initial begin
    weight_q = pcs_pkg::EXPLORE_RESET;
    lead_score = 32'sh80000000;
    lead_action = '0;
    lead_loss = '0;
    lead_valid = 1'b0;
    children_seen = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    out_stall_bias = 20;
    test_weights();
    test_random_nodes();
    if (fail_count == 0) $display("** puct_child_select_core: PASSED **");
    else $display("** puct_child_select_core: FAILED **");
    $finish;
  end
endmodule

// ===== puct_child_select_core.f =====
hdl/pcs_pkg.sv
hdl/pcs_ctrl.sv
hdl/pcs_dp.sv
hdl/puct_child_select_core.sv
bench/tb_top.sv
